### rtl/bgbd_pkg.sv
// Types, constants and helper functions shared by the demosaic block.
package bgbd_pkg;

	localparam int PixW = 8;
	localparam int CntW = 12;
	localparam int OutW = 11;
	localparam int CfgW = 12;
	localparam int IdxW = 8;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = QPtrW + 1;
	localparam int HeightLimit = 2048;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_PIX_PER_ROW = IdxW'(0);
	localparam logic [IdxW-1:0] REG_ROWS_PER_FRAME = IdxW'(1);
	localparam logic [IdxW-1:0] REG_GRAY_MODE = IdxW'(2);
	localparam logic [IdxW-1:0] REG_BLUE_FIRST = IdxW'(3);

	localparam logic [CfgW-1:0] RST_PIX_PER_ROW = CfgW'(640);
	localparam logic [CfgW-1:0] RST_ROWS_PER_FRAME = CfgW'(480);

	// Luma weights.
	localparam logic [7:0] LUMA_R = 8'd77;
	localparam logic [7:0] LUMA_G = 8'd151;
	localparam logic [7:0] LUMA_B = 8'd28;

	typedef struct packed {
		logic [CfgW-1:0] pix_per_row;
		logic [CfgW-1:0] rows_per_frame;
		logic gray_mode;
		logic blue_first;
	} cfg_t;

	// One interpolated pixel with its border copies, handed from front to back.
	typedef struct packed {
		logic [OutW-1:0] row_a;
		logic [OutW-1:0] row_b;
		logic [OutW-1:0] col_a;
		logic [OutW-1:0] col_b;
		logic two_rows;
		logic two_cols;
		logic done;
		logic [PixW-1:0] red;
		logic [PixW-1:0] grn;
		logic [PixW-1:0] blu;
	} job_t;

	function automatic logic [PixW-1:0] luma(input logic [PixW-1:0] r,
		input logic [PixW-1:0] g, input logic [PixW-1:0] b);
		logic [17:0] sum;
		begin
			sum = 18'(r * LUMA_R) + 18'(g * LUMA_G) + 18'(b * LUMA_B);
			luma = sum[15:8];
		end
	endfunction

	function automatic logic [PixW-1:0] avg2(input logic [PixW-1:0] a,
		input logic [PixW-1:0] b);
		logic [PixW:0] s;
		begin
			s = {1'b0, a} + {1'b0, b} + (PixW+1)'(1);
			avg2 = s[PixW:1];
		end
	endfunction

	function automatic logic [PixW-1:0] avg4(input logic [PixW-1:0] a,
		input logic [PixW-1:0] b, input logic [PixW-1:0] c, input logic [PixW-1:0] d);
		logic [PixW+1:0] s;
		begin
			s = (PixW+2)'(a) + (PixW+2)'(b) + (PixW+2)'(c) + (PixW+2)'(d) + (PixW+2)'(2);
			avg4 = s[PixW+1:2];
		end
	endfunction

endpackage

### rtl/bgbd_if.sv
// Channel interfaces: raw pixel input, result output and configuration writes.
interface bgbd_pix_if;
	import bgbd_pkg::*;
	logic valid;
	logic ready;
	logic [PixW-1:0] raw_pixel;
	logic frame_start;
	modport source (output valid, output raw_pixel, output frame_start, input ready);
	modport sink (input valid, input raw_pixel, input frame_start, output ready);
endinterface

interface bgbd_res_if;
	import bgbd_pkg::*;
	logic valid;
	logic ready;
	logic [OutW-1:0] out_row;
	logic [OutW-1:0] out_col;
	logic [PixW-1:0] chan_first;
	logic [PixW-1:0] chan_green;
	logic [PixW-1:0] chan_third;
	logic frame_done;
	logic run_end;
	modport source (output valid, output out_row, output out_col, output chan_first,
		output chan_green, output chan_third, output frame_done, output run_end,
		input ready);
	modport sink (input valid, input out_row, input out_col, input chan_first,
		input chan_green, input chan_third, input frame_done, input run_end,
		output ready);
endinterface

interface bgbd_cfg_if;
	import bgbd_pkg::*;
	logic valid;
	logic ready;
	logic [IdxW-1:0] index;
	logic [CfgW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bgbd_ram.sv
// Generic simple dual-port RAM with registered read.
module bgbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/bgbd_front.sv
// Front end: position counters, line stores, 3x3 window and interpolation.
module bgbd_front #(
	parameter int MAX_WIDTH = 2048
) (
	input logic clk,
	input logic arst_n,
	input bgbd_pkg::cfg_t cfg,
	bgbd_pix_if.sink pix_in,
	input logic [bgbd_pkg::QCntW-1:0] q_count,
	output logic job_valid,
	output bgbd_pkg::job_t job
);
	import bgbd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int XW = CntW + 2;
	localparam logic [XW-1:0] WidthLim = XW'(MAX_WIDTH & ~1);
	localparam logic [XW-1:0] WidthMax = XW'(MAX_WIDTH);

	logic [CntW-1:0] w_eff, h_eff, w_even, h_even;
	logic [CntW-1:0] row_q, col_q, row_cur, col_cur;
	logic [CntW:0] col_inc;
	logic [CntW-1:0] row_inc;
	logic [AW-1:0] idx;
	logic acc;

	logic v_s1, v_s2, byp_s1;
	logic [PixW-1:0] pix_s1;
	logic [AW-1:0] idx_s1;
	logic [CntW-1:0] row_s1, col_s1, row_s2, col_s2;
	logic [2*PixW-1:0] fwd_s1, ram_rdata, rd, ram_wdata;
	logic [PixW-1:0] a_old, b_old;
	logic [PixW-1:0] win_q [9];

	// Effective frame size: even, clamped to the supported range.
	always_comb begin
		w_even = {cfg.pix_per_row[CfgW-1:1], 1'b0};
		h_even = {cfg.rows_per_frame[CfgW-1:1], 1'b0};
		if (w_even < CntW'(4)) begin
			w_eff = CntW'(4);
		end else if (XW'(w_even) > WidthLim) begin
			w_eff = CntW'(WidthLim);
		end else begin
			w_eff = w_even;
		end
		if (h_even < CntW'(4)) begin
			h_eff = CntW'(4);
		end else if (h_even > CntW'(HeightLimit)) begin
			h_eff = CntW'(HeightLimit);
		end else begin
			h_eff = h_even;
		end
	end

	// Accept while the queue has room for every item already in flight.
	assign pix_in.ready = (QCntW+1)'(q_count) + (QCntW+1)'(v_s1) + (QCntW+1)'(v_s2)
		< (QCntW+1)'(QDepth);
	assign acc = pix_in.valid & pix_in.ready;

	always_comb begin
		row_cur = pix_in.frame_start ? '0 : row_q;
		col_cur = pix_in.frame_start ? '0 : col_q;
		idx = (XW'(col_cur) < WidthMax) ? AW'(col_cur) : '0;
		col_inc = {1'b0, col_cur} + (CntW+1)'(1);
		row_inc = row_cur + CntW'(1);
	end

	// Position of the next sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (col_inc >= {1'b0, w_eff}) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc;
			end else begin
				col_q <= CntW'(col_inc);
				row_q <= row_cur;
			end
		end
	end

	// Both line stores share one RAM: upper byte is two rows back, lower byte one row back.
	bgbd_ram #(.WIDTH(2*PixW), .DEPTH(MAX_WIDTH)) u_lines (
		.clk(clk),
		.we(v_s1),
		.waddr(idx_s1),
		.wdata(ram_wdata),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	// A write in flight to the address being read is forwarded.
	assign rd = byp_s1 ? fwd_s1 : ram_rdata;
	assign a_old = rd[PixW-1:0];
	assign b_old = rd[2*PixW-1:PixW];
	assign ram_wdata = {a_old, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			byp_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			byp_s1 <= acc && v_s1 && (idx_s1 == idx);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= pix_in.raw_pixel;
			idx_s1 <= idx;
			row_s1 <= row_cur;
			col_s1 <= col_cur;
			fwd_s1 <= ram_wdata;
		end
		if (v_s1) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	// Window shift: column 2 takes the newest samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3] <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= b_old;
			win_q[5] <= a_old;
			win_q[8] <= pix_s1;
		end
	end

	// Interpolation and border classification of the window centre.
	logic [CntW-1:0] rr, cc;
	logic [PixW-1:0] hor, ver, crs, dia, ctr;
	logic emit, top, bot, lft, rgt;

	always_comb begin
		rr = row_s2 - CntW'(1);
		cc = col_s2 - CntW'(1);
		ctr = win_q[4];
		hor = avg2(win_q[3], win_q[5]);
		ver = avg2(win_q[1], win_q[7]);
		crs = avg4(win_q[1], win_q[3], win_q[5], win_q[7]);
		dia = avg4(win_q[0], win_q[2], win_q[6], win_q[8]);
		emit = (row_s2 >= CntW'(2)) && (col_s2 >= CntW'(2)) &&
			(row_s2 <= h_eff - CntW'(1)) && (col_s2 <= w_eff - CntW'(1));
		top = rr == CntW'(1);
		bot = rr == h_eff - CntW'(2);
		lft = cc == CntW'(1);
		rgt = cc == w_eff - CntW'(2);
		case ({rr[0], cc[0]})
			2'b00: begin job.red = hor; job.grn = ctr; job.blu = ver; end
			2'b01: begin job.red = ctr; job.grn = crs; job.blu = dia; end
			2'b10: begin job.red = dia; job.grn = crs; job.blu = ctr; end
			2'b11: begin job.red = ver; job.grn = ctr; job.blu = hor; end
			default: begin job.red = ctr; job.grn = ctr; job.blu = ctr; end
		endcase
		job.row_a = top ? '0 : OutW'(rr);
		job.row_b = top ? OutW'(rr) : OutW'(h_eff - CntW'(1));
		job.col_a = lft ? '0 : OutW'(cc);
		job.col_b = lft ? OutW'(cc) : OutW'(w_eff - CntW'(1));
		job.two_rows = top | bot;
		job.two_cols = lft | rgt;
		job.done = bot & rgt;
		job_valid = v_s2 & emit;
	end
endmodule

### rtl/bgbd_queue.sv
// Short queue of interpolated pixels between the front and back ends.
module bgbd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bgbd_pkg::job_t push_job,
	input logic pop,
	output logic head_valid,
	output bgbd_pkg::job_t head,
	output logic [bgbd_pkg::QCntW-1:0] count
);
	import bgbd_pkg::*;

	job_t slot_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop & head_valid;
	assign head_valid = cnt_q != '0;
	assign head = slot_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPtrW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(do_pop);
		end
	end
endmodule

### rtl/bgbd_back.sv
// Back end: expands each pixel into its border copies and formats the channels.
module bgbd_back (
	input logic clk,
	input logic arst_n,
	input bgbd_pkg::cfg_t cfg,
	input logic head_valid,
	input bgbd_pkg::job_t head,
	output logic pop,
	bgbd_res_if.source res_out
);
	import bgbd_pkg::*;

	logic ai_q, bi_q, out_valid_q, load, last;
	logic [OutW-1:0] row_q, col_q;
	logic [PixW-1:0] first_q, green_q, third_q;
	logic done_q, run_end_q;

	assign load = !out_valid_q || res_out.ready;
	assign last = (ai_q == head.two_rows) && (bi_q == head.two_cols);
	assign pop = load && head_valid && last;

	// Copy counter: columns inside rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ai_q <= 1'b0;
			bi_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (last) begin
					ai_q <= 1'b0;
					bi_q <= 1'b0;
				end else if (bi_q == head.two_cols) begin
					ai_q <= 1'b1;
					bi_q <= 1'b0;
				end else begin
					bi_q <= 1'b1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			row_q <= ai_q ? head.row_b : head.row_a;
			col_q <= bi_q ? head.col_b : head.col_a;
			done_q <= head.done && last;
			run_end_q <= last;
			if (cfg.gray_mode) begin
				first_q <= luma(head.red, head.grn, head.blu);
				green_q <= '0;
				third_q <= '0;
			end else begin
				first_q <= cfg.blue_first ? head.blu : head.red;
				green_q <= head.grn;
				third_q <= cfg.blue_first ? head.red : head.blu;
			end
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.out_row = row_q;
	assign res_out.out_col = col_q;
	assign res_out.chan_first = first_q;
	assign res_out.chan_green = green_q;
	assign res_out.chan_third = third_q;
	assign res_out.frame_done = done_q;
	assign res_out.run_end = run_end_q;
endmodule

### rtl/bayer_grbg_bilinear_demosaic.sv
// Top level of the GRBG Bayer bilinear demosaic block.
//
// Channel  Dir  Payload                                              Transfer
// pix_in   in   raw_pixel[7:0], frame_start                          valid & ready
// res_out  out  out_row, out_col, chan_first/green/third, frame_done,
//               run_end                                              valid & ready
// cfg      in   index[7:0], data[11:0]                               valid & ready
//
// One raw sample is taken per cycle while input ready is high; a pixel whose
// border copies give several results stays at the queue head until its last result is loaded.
// A sample passes the line store read and then the window before it enters the
// queue, and from the queue head its results are loaded into the output register.
// Input ready drops when the queue and the front stages together hold four pixels.
// Reset clears counters, window and control; the line stores are not cleared.
module bayer_grbg_bilinear_demosaic #(
	parameter int MAX_WIDTH = 2048
) (
	input logic clk,
	input logic arst_n,
	bgbd_pix_if.sink pix_in,
	bgbd_res_if.source res_out,
	bgbd_cfg_if.sink cfg
);
	import bgbd_pkg::*;

	cfg_t cfg_q;
	job_t job, head;
	logic job_valid, head_valid, pop;
	logic [QCntW-1:0] q_count;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pix_per_row <= RST_PIX_PER_ROW;
			cfg_q.rows_per_frame <= RST_ROWS_PER_FRAME;
			cfg_q.gray_mode <= 1'b0;
			cfg_q.blue_first <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PIX_PER_ROW: cfg_q.pix_per_row <= cfg.data;
				REG_ROWS_PER_FRAME: cfg_q.rows_per_frame <= cfg.data;
				REG_GRAY_MODE: cfg_q.gray_mode <= cfg.data[0];
				REG_BLUE_FIRST: cfg_q.blue_first <= cfg.data[0];
				default: ;
			endcase
		end
	end

	bgbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pix_in(pix_in),
		.q_count(q_count),
		.job_valid(job_valid),
		.job(job)
	);

	bgbd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_valid),
		.push_job(job),
		.pop(pop),
		.head_valid(head_valid),
		.head(head),
		.count(q_count)
	);

	bgbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.res_out(res_out)
	);
endmodule

### tb/bgbd_tb_if.sv
`timescale 1ns / 100ps
// Testbench package: the record type for expected and observed results.
package bgbd_tb_pkg;
	import bgbd_pkg::*;

	// One expected or observed result of the demosaic block.
	typedef struct packed {
		logic [OutW-1:0] out_row;
		logic [OutW-1:0] out_col;
		logic [PixW-1:0] chan_first;
		logic [PixW-1:0] chan_green;
		logic [PixW-1:0] chan_third;
		logic frame_done;
		logic run_end;
	} demosaic_res_t;
endpackage

### tb/bayer_grbg_bilinear_demosaic_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GRBG Bayer bilinear demosaic block.
module bayer_grbg_bilinear_demosaic_tb;
	import bgbd_pkg::*;
	import bgbd_tb_pkg::*;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	bgbd_pix_if pix();
	bgbd_res_if res();
	bgbd_cfg_if cfgc();

	bayer_grbg_bilinear_demosaic dut (.clk(clk), .arst_n(arst_n), .pix_in(pix),
		.res_out(res), .cfg(cfgc));

	// Shadow copy of the block state.
	logic [PixW-1:0] prev_line [0:2047];
	logic [PixW-1:0] older_line [0:2047];
	logic [PixW-1:0] win3 [0:8];
	int unsigned next_row, next_col;
	int unsigned cfg_width, cfg_height;
	logic cfg_gray, cfg_bgr;

	demosaic_res_t pending_pixels[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
		int unsigned s;
		s = v & ~32'd1;
		if (s < 4) s = 4;
		if (s > lim) s = lim;
		return s;
	endfunction

	function automatic logic [PixW-1:0] mean2(input int unsigned a, input int unsigned b);
		return PixW'((a + b + 1) >> 1);
	endfunction

	function automatic logic [PixW-1:0] mean4(input int unsigned a, input int unsigned b,
		input int unsigned c, input int unsigned d);
		return PixW'((a + b + c + d + 2) >> 2);
	endfunction

	// Advances the shadow state by one sample and queues the pixels it completes.
	task automatic predict_demosaic(input logic [PixW-1:0] raw, input logic fs);
		int unsigned w, h, idx, rr, cc, nr, nc, red, grn, blu, hor, ver, crs, dia, ctr;
		int unsigned rws[3];
		int unsigned cls[2];
		demosaic_res_t r;
		w = clamp_size(cfg_width, 2048);
		h = clamp_size(cfg_height, HeightLimit);
		if (fs) begin
			next_row = 0;
			next_col = 0;
		end
		idx = (next_col < 2048) ? next_col : 0;
		for (int i = 0; i < 3; i++) begin
			win3[i*3] = win3[i*3+1];
			win3[i*3+1] = win3[i*3+2];
		end
		win3[2] = older_line[idx];
		win3[5] = prev_line[idx];
		win3[8] = raw;
		older_line[idx] = prev_line[idx];
		prev_line[idx] = raw;
		if (next_row >= 2 && next_col >= 2 && next_row - 1 <= h - 2 &&
			next_col - 1 <= w - 2) begin
			rr = next_row - 1;
			cc = next_col - 1;
			ctr = win3[4];
			hor = mean2(win3[3], win3[5]);
			ver = mean2(win3[1], win3[7]);
			crs = mean4(win3[1], win3[3], win3[5], win3[7]);
			dia = mean4(win3[0], win3[2], win3[6], win3[8]);
			if (rr[0] == 1'b0) begin
				if (cc[0] == 1'b0) begin
					red = hor; grn = ctr; blu = ver;
				end else begin
					red = ctr; grn = crs; blu = dia;
				end
			end else begin
				if (cc[0] == 1'b0) begin
					red = dia; grn = crs; blu = ctr;
				end else begin
					red = ver; grn = ctr; blu = hor;
				end
			end
			nr = 0;
			nc = 0;
			if (rr == 1) begin
				rws[nr] = 0;
				nr = nr + 1;
			end
			rws[nr] = rr;
			nr = nr + 1;
			if (rr == h - 2) begin
				rws[nr] = h - 1;
				nr = nr + 1;
			end
			if (cc == 1) begin
				cls[nc] = 0;
				nc = nc + 1;
			end
			cls[nc] = cc;
			nc = nc + 1;
			if (cc == w - 2 && nc < 2) begin
				cls[nc] = w - 1;
				nc = nc + 1;
			end
			if (nr > 2) nr = 2;
			for (int a = 0; a < nr; a++) begin
				for (int b = 0; b < nc; b++) begin
					r.out_row = OutW'(rws[a]);
					r.out_col = OutW'(cls[b]);
					if (cfg_gray) begin
						r.chan_first = PixW'((red * 77 + grn * 151 + blu * 28) >> 8);
						r.chan_green = '0;
						r.chan_third = '0;
					end else begin
						r.chan_first = PixW'(cfg_bgr ? blu : red);
						r.chan_green = PixW'(grn);
						r.chan_third = PixW'(cfg_bgr ? red : blu);
					end
					r.frame_done = (rws[a] == h - 1 && cls[b] == w - 1);
					r.run_end = 1'b0;
					pending_pixels.push_back(r);
				end
			end
			pending_pixels[pending_pixels.size()-1].run_end = 1'b1;
		end
		next_col++;
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
			if (next_row >= h) next_row = 0;
		end
	endtask

	// Sends one sample, honouring the idle ratio of the current phase.
	// Valid stays high on return; the next call or drain() takes it down.
	task automatic send_pixel(input logic [PixW-1:0] raw, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.raw_pixel <= raw;
		pix.frame_start <= fs;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		predict_demosaic(raw, fs);
		items_sent++;
		@(negedge clk);
	endtask

	// Register write through the configuration channel; set_frame() ends the burst.
	task automatic write_reg(input logic [IdxW-1:0] index, input int unsigned value);
		cfgc.valid <= 1'b1;
		cfgc.index <= index;
		cfgc.data <= CfgW'(value);
		@(posedge clk);
		while (!cfgc.ready) @(posedge clk);
		case (index)
			REG_PIX_PER_ROW: cfg_width = value & 12'hFFF;
			REG_ROWS_PER_FRAME: cfg_height = value & 12'hFFF;
			REG_GRAY_MODE: cfg_gray = value[0];
			REG_BLUE_FIRST: cfg_bgr = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits until every queued pixel has arrived, then lets the pipeline settle.
	task automatic drain;
		pix.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h, input logic g,
		input logic b);
		drain();
		write_reg(REG_PIX_PER_ROW, w);
		write_reg(REG_ROWS_PER_FRAME, h);
		write_reg(REG_GRAY_MODE, g);
		write_reg(REG_BLUE_FIRST, b);
		cfgc.valid <= 1'b0;
	endtask

	// Full frame of random samples; the first sample of each frame carries frame_start.
	task automatic random_frame(input int unsigned w, input int unsigned h);
		int unsigned ew, eh;
		ew = clamp_size(w, 2048);
		eh = clamp_size(h, HeightLimit);
		for (int i = 0; i < ew * eh; i++)
			send_pixel(PixW'($urandom_range(255)), i == 0);
	endtask

	// Receiver ready, with random stalls and one long hold-off.
	always @(negedge clk) begin
		if (hold_off) res.ready <= 1'b0;
		else res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		demosaic_res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.out_row, res.out_col, res.chan_first, res.chan_green,
				res.chan_third, res.frame_done, res.run_end};
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$error("Unexpected result row %0d col %0d", got.out_row, got.out_col);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (got.out_row !== want.out_row) begin
					$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
					errors++;
				end
				if (got.out_col !== want.out_col) begin
					$error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
					errors++;
				end
				if (got.chan_first !== want.chan_first) begin
					$error("chan_first: expected %0d, got %0d", want.chan_first,
						got.chan_first);
					errors++;
				end
				if (got.chan_green !== want.chan_green) begin
					$error("chan_green: expected %0d, got %0d", want.chan_green,
						got.chan_green);
					errors++;
				end
				if (got.chan_third !== want.chan_third) begin
					$error("chan_third: expected %0d, got %0d", want.chan_third,
						got.chan_third);
					errors++;
				end
				if (got.frame_done !== want.frame_done) begin
					$error("frame_done: expected %0d, got %0d", want.frame_done,
						got.frame_done);
					errors++;
				end
				if (got.run_end !== want.run_end) begin
					$error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Directed frames: extremes of the pixel values on a minimum frame.
	typedef struct {
		logic [PixW-1:0] raw;
		logic fs;
	} pix_row_t;

	pix_row_t extreme_rows[16];

	initial begin
		pix.valid = 1'b0;
		pix.raw_pixel = '0;
		pix.frame_start = 1'b0;
		cfgc.valid = 1'b0;
		cfgc.index = '0;
		cfgc.data = '0;
		res.ready = 1'b0;
		for (int i = 0; i < 9; i++) win3[i] = '0;
		for (int i = 0; i < 2048; i++) begin
			prev_line[i] = '0;
			older_line[i] = '0;
		end
		next_row = 0;
		next_col = 0;
		cfg_width = 640;
		cfg_height = 480;
		cfg_gray = 1'b0;
		cfg_bgr = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: 4x4 frame with checkerboard extremes, every site colour hit.
		for (int i = 0; i < 16; i++) begin
			extreme_rows[i].raw = ((i + i / 4) % 2 == 0) ? 8'hFF : 8'h00;
			extreme_rows[i].fs = (i == 0);
		end
		set_frame(4, 4, 1'b0, 1'b0);
		foreach (extreme_rows[i]) send_pixel(extreme_rows[i].raw, extreme_rows[i].fs);
		// Same frame again wraps without frame_start.
		foreach (extreme_rows[i]) send_pixel(~extreme_rows[i].raw, 1'b0);

		// Odd and out-of-range sizes, gray mode and channel swap.
		set_frame(5, 3, 1'b1, 1'b0);
		random_frame(5, 3);
		set_frame(6, 4, 1'b0, 1'b1);
		random_frame(6, 4);

		// Random phases with varying idling.
		send_idle_pct = 0;  recv_stall_pct = 0;
		set_frame(8, 6, 1'b0, 1'b0);
		random_frame(8, 6);
		send_idle_pct = 67; recv_stall_pct = 0;
		set_frame(4, 6, 1'b1, 1'b1);
		random_frame(4, 6);
		send_idle_pct = 0;  recv_stall_pct = 67;
		set_frame(10, 4, 1'b0, 1'b1);
		random_frame(10, 4);
		send_idle_pct = 24; recv_stall_pct = 24;
		set_frame(6, 6, 1'b1, 1'b0);
		random_frame(6, 6);

		// Long receiver hold-off while samples keep arriving.
		send_idle_pct = 0;  recv_stall_pct = 0;
		set_frame(4, 4, 1'b0, 1'b0);
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			random_frame(4, 4);
		join

		// Odd width and height on a larger frame with mixed idling.
		set_frame(13, 7, 1'b0, 1'b1);
		send_idle_pct = 24; recv_stall_pct = 24;
		random_frame(13, 7);

		drain();
		$display("Covered %0d samples and %0d results over several frame sizes,", items_sent,
			results_seen);
		$display("colour orders, gray mode, stalls and a long output hold-off.");
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
